FILE: design/lora_airtime_calculator_assert.svh
// assertion macros for the lora airtime calculator
// used by lora_airtime_calculator and lac_out_buf, no other dependencies
`ifndef LORA_AIRTIME_CALCULATOR_ASSERT_SVH
`define LORA_AIRTIME_CALCULATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define LAC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

`define LAC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LAC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)

`define LAC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

FILE: design/lac_pkg.sv
// shared widths, register indexes, stage structs and constant tables
// for the lora airtime calculator; no dependencies
package lac_pkg;

  localparam int PL_W       = 8;
  localparam int TOA_W      = 36;
  localparam int TSYM_W     = 20;
  localparam int PSYM_W     = 10;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int BWC_W = 4;
  localparam int SF_W  = 4;
  localparam int PRE_W = 16;
  localparam int CR_W  = 3;

  localparam int NUM_W      = 14;
  localparam int DEN_W      = 9;
  localparam int REM_W      = DEN_W + 1;
  localparam int DIV_W      = 48;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;

  localparam int M_W       = 10;
  localparam int RECIP_W   = 17;
  localparam int PROD_W    = M_W + RECIP_W;
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 7;
  localparam int QTR_W     = 19;
  localparam int X_W       = QTR_W + NUM_W;

  localparam logic [CFG_IDX_W-1:0] REG_BANDWIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SF        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMPLICIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CR        = 3'd4;

  localparam logic [BWC_W-1:0] BWC_RST = 4'd7;
  localparam logic [SF_W-1:0]  SF_RST  = 4'd12;
  localparam logic [PRE_W-1:0] PRE_RST = 16'd8;
  localparam logic [CR_W-1:0]  CR_RST  = 3'd1;

  localparam logic [BWC_W-1:0] BWC_MAX = 4'd9;
  localparam logic [SF_W-1:0]  SF_MIN  = 4'd6;
  localparam logic [SF_W-1:0]  SF_MAX  = 4'd12;
  localparam logic [SF_W-1:0]  SF_LDR  = 4'd10;
  localparam logic [CR_W-1:0]  CR_MIN  = 3'd1;
  localparam logic [CR_W-1:0]  CR_MAX  = 3'd4;

  localparam logic [PSYM_W-1:0] PSYM_FIXED  = 10'd8;
  localparam logic [QTR_W-1:0]  PRE_QUARTER = 19'd17;

  typedef struct packed {
    logic [BWC_W-1:0] bwc;
    logic [SF_W-1:0]  sf;
    logic [PRE_W-1:0] pre;
    logic             hdr;
    logic [CR_W-1:0]  cr;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [PSYM_W-1:0] psym;
  } sym_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic              valid;
    div_lane_t         toa;
    div_lane_t         tsym;
    logic [PSYM_W-1:0] psym;
  } div_t;

  typedef struct packed {
    logic [TOA_W-1:0]  toa;
    logic [TSYM_W-1:0] tsym;
    logic [PSYM_W-1:0] psym;
  } res_t;

  // 1e6 / bandwidth as a reduced fraction num / den
  function automatic logic [NUM_W-1:0] bw_num(input logic [BWC_W-1:0] bwc);
    logic [NUM_W-1:0] n;
    case (bwc)
      4'd0:    n = 14'd5000;
      4'd1:    n = 14'd1250;
      4'd2:    n = 14'd2500;
      4'd3:    n = 14'd625;
      4'd4:    n = 14'd32;
      4'd5:    n = 14'd10000;
      4'd6:    n = 14'd16;
      4'd7:    n = 14'd8;
      4'd8:    n = 14'd4;
      default: n = 14'd2;
    endcase
    return n;
  endfunction

  function automatic logic [DEN_W-1:0] bw_den(input logic [BWC_W-1:0] bwc);
    logic [DEN_W-1:0] d;
    case (bwc)
      4'd0:    d = 9'd39;
      4'd1:    d = 9'd13;
      4'd2:    d = 9'd39;
      4'd3:    d = 9'd13;
      4'd5:    d = 9'd417;
      default: d = 9'd1;
    endcase
    return d;
  endfunction

  // ceil(2^16 / k), exact floor for dividends below 2^10
  function automatic logic [RECIP_W-1:0] recip(input logic [SF_W-1:0] k);
    logic [RECIP_W-1:0] r;
    case (k)
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = 17'd6554;
    endcase
    return r;
  endfunction

endpackage

FILE: design/lac_symbols.sv
// payload symbol count: three stages from payload length to symbols
// depends on lac_pkg
module lac_symbols import lac_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [PL_W-1:0] in_pl,
  input  cfg_t            cfg,
  output sym_t            sym_o
);

  logic [11:0]        a;
  logic [6:0]         b;
  logic [11:0]        n;
  logic [11:0]        n_up;
  logic [SF_W-1:0]    k;
  logic [M_W-1:0]     mk_nxt;
  logic [PROD_W-1:0]  prod_nxt;
  logic [Q_W-1:0]     q;
  logic [10:0]        qc;
  logic [PSYM_W-1:0]  psym_nxt;

  logic               v1_r, v2_r, v3_r;
  logic [M_W-1:0]     mk_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PSYM_W-1:0]  psym_r;

  always_comb begin
    a      = {1'b0, in_pl, 3'b000} + 12'd44;
    b      = {1'b0, cfg.sf, 2'b00} + (cfg.hdr ? 7'd20 : 7'd0);
    k      = (cfg.sf > SF_LDR) ? cfg.sf - 4'd2 : cfg.sf;
    n      = (a > {5'b0, b}) ? a - {5'b0, b} : 12'd0;
    n_up   = n + 12'd3;
    mk_nxt = n_up[11:2] + {6'b0, k} - 10'd1;
  end

  assign prod_nxt = PROD_W'(mk_r) * PROD_W'(recip(k));

  always_comb begin
    q        = prod_r[FRAC_BITS +: Q_W];
    qc       = 11'(q) * 11'({1'b0, cfg.cr} + 4'd4);
    psym_nxt = PSYM_FIXED + qc[PSYM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mk_r   <= mk_nxt;
      prod_r <= prod_nxt;
      psym_r <= psym_nxt;
    end
  end

  assign sym_o.valid = v3_r;
  assign sym_o.psym  = psym_r;

endmodule

FILE: design/lac_scale.sv
// scales symbols to quarter-symbol chips and forms divider dividends
// depends on lac_pkg
module lac_scale import lac_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  sym_t sym_i,
  input  cfg_t cfg,
  output div_t div_o
);

  logic [NUM_W-1:0]  num;
  logic [QTR_W-1:0]  quarters;
  logic [X_W-1:0]    x_nxt;
  div_t              div_nxt;

  logic              v4_r;
  logic [X_W-1:0]    x_r;
  logic [PSYM_W-1:0] psym_r;
  div_t              div_r;

  assign num = bw_num(cfg.bwc);

  always_comb begin
    quarters = {1'b0, cfg.pre, 2'b00} + PRE_QUARTER + QTR_W'({sym_i.psym, 2'b00});
    x_nxt    = X_W'(quarters) * X_W'(num);
  end

  always_comb begin
    div_nxt.valid    = v4_r;
    div_nxt.psym     = psym_r;
    div_nxt.toa.rem  = '0;
    div_nxt.toa.quo  = DIV_W'(x_r) << (cfg.sf - 4'd2);
    div_nxt.tsym.rem = '0;
    div_nxt.tsym.quo = DIV_W'(num) << cfg.sf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= sym_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      psym_r <= sym_i.psym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.valid <= 1'b0;
    end else if (en) begin
      div_r <= div_nxt;
    end
  end

  assign div_o = div_r;

endmodule

FILE: design/lac_div_stage.sv
// one restoring-division stage, a few quotient bits for two lanes
// depends on lac_pkg
module lac_div_stage import lac_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [DEN_W-1:0] den,
  input  div_t             d_i,
  output div_t             d_o
);

  div_t d_nxt;
  div_t d_r;

  function automatic div_lane_t div_step(input div_lane_t l, input logic [DEN_W-1:0] d);
    div_lane_t        o;
    logic [REM_W-1:0] r;
    r     = {l.rem[REM_W-2:0], l.quo[DIV_W-1]};
    o.quo = {l.quo[DIV_W-2:0], 1'b0};
    if (r >= {1'b0, d}) begin
      r        = r - {1'b0, d};
      o.quo[0] = 1'b1;
    end
    o.rem = r;
    return o;
  endfunction

  always_comb begin
    d_nxt = d_i;
    for (int i = 0; i < DIV_STEPS; i++) begin
      d_nxt.toa  = div_step(d_nxt.toa, den);
      d_nxt.tsym = div_step(d_nxt.tsym, den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

FILE: design/lac_out_buf.sv
// two-entry output buffer: output register plus skid entry
// depends on lac_pkg and the assertion macro header
`include "lora_airtime_calculator_assert.svh"
module lac_out_buf import lac_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  res_t push_data,
  input  logic out_ready,
  output logic out_valid,
  output res_t out_data,
  output logic can_take
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_data_r, out_data_nxt;
  res_t skid_data_r, skid_data_nxt;
  logic push, pop;

  assign push = push_valid && !skid_valid_r;
  assign pop  = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        if (push) begin
          out_data_nxt = push_data;
        end
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_take  = !skid_valid_r;

  `LAC_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_r, out_valid_r, "skid entry without output entry")
  `LAC_ASSERT_NXT(a_skid_kept, clk, rst_n, skid_valid_r && !out_ready, skid_valid_r && $stable(skid_data_r), "skid entry lost while stalled")
  `LAC_ASSERT_NXT(a_push_to_skid, clk, rst_n, push && out_valid_r && !out_ready, skid_valid_r, "result dropped on stall")

endmodule

FILE: design/lora_airtime_calculator.sv
// Time on air, symbol time and payload symbol count for one payload length per request.
// Fully pipelined: a request enters on any cycle in_ready is high and its result
// passes through 3 symbol-count stages, 2 scaling stages, 6 restoring-divider stages
// of 8 quotient bits each, then the output register. Sustained rate is one request
// per cycle; a two-entry output buffer absorbs a stall of the result side,
// and in_ready drops only while both entries are full. Settings are to be written through
// the cfg port while no request is in flight, which the block does not enforce; they take
// effect on the next request. Out-of-range settings saturate to the nearest legal value.
// depends on lac_pkg, lac_symbols, lac_scale, lac_div_stage, lac_out_buf
`include "lora_airtime_calculator_assert.svh"
module lora_airtime_calculator import lac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PL_W-1:0]       in_payload_length,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TOA_W-1:0]      out_time_on_air_us,
  output logic [TSYM_W-1:0]     out_symbol_time_us,
  output logic [PSYM_W-1:0]     out_payload_symbols,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [TSYM_W-1:0] TSYM_MIN = 20'd128;

  logic [BWC_W-1:0] bwc_r;
  logic [SF_W-1:0]  sf_r;
  logic [PRE_W-1:0] pre_r;
  logic             hdr_r;
  logic [CR_W-1:0]  cr_r;

  cfg_t             cfg;
  logic             en;
  logic [DEN_W-1:0] den;
  sym_t             sym;
  div_t             div_chain [0:DIV_STAGES];
  res_t             res;
  res_t             out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bwc_r <= BWC_RST;
      sf_r  <= SF_RST;
      pre_r <= PRE_RST;
      hdr_r <= 1'b0;
      cr_r  <= CR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BANDWIDTH: begin
          bwc_r <= cfg_data[BWC_W-1:0];
        end
        REG_SF: begin
          sf_r <= cfg_data[SF_W-1:0];
        end
        REG_PREAMBLE: begin
          pre_r <= cfg_data[PRE_W-1:0];
        end
        REG_IMPLICIT: begin
          hdr_r <= cfg_data[0];
        end
        REG_CR: begin
          cr_r <= cfg_data[CR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.bwc = (bwc_r > BWC_MAX) ? BWC_MAX : bwc_r;
    if (sf_r inside {[SF_MIN:SF_MAX]}) begin
      cfg.sf = sf_r;
    end else if (sf_r < SF_MIN) begin
      cfg.sf = SF_MIN;
    end else begin
      cfg.sf = SF_MAX;
    end
    if (cr_r inside {[CR_MIN:CR_MAX]}) begin
      cfg.cr = cr_r;
    end else if (cr_r < CR_MIN) begin
      cfg.cr = CR_MIN;
    end else begin
      cfg.cr = CR_MAX;
    end
    cfg.pre = pre_r;
    cfg.hdr = hdr_r;
  end

  assign den      = bw_den(cfg.bwc);
  assign in_ready = en;

  lac_symbols u_symbols (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_pl    (in_payload_length),
    .cfg      (cfg),
    .sym_o    (sym)
  );

  lac_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .sym_i (sym),
    .cfg   (cfg),
    .div_o (div_chain[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    lac_div_stage u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .den   (den),
      .d_i   (div_chain[g]),
      .d_o   (div_chain[g+1])
    );
  end

  always_comb begin
    res.toa  = div_chain[DIV_STAGES].toa.quo[TOA_W-1:0];
    res.tsym = div_chain[DIV_STAGES].tsym.quo[TSYM_W-1:0];
    res.psym = div_chain[DIV_STAGES].psym;
  end

  lac_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (div_chain[DIV_STAGES].valid),
    .push_data  (res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .can_take   (en)
  );

  assign out_time_on_air_us  = out_data.toa;
  assign out_symbol_time_us  = out_data.tsym;
  assign out_payload_symbols = out_data.psym;

  `LAC_ASSERT_IMP(a_psym_floor, clk, rst_n, out_valid, out_payload_symbols >= PSYM_FIXED, "payload symbols below fixed count")
  `LAC_ASSERT_IMP(a_tsym_floor, clk, rst_n, out_valid, out_symbol_time_us >= TSYM_MIN, "symbol time below shortest symbol")
  `LAC_ASSERT_IMP(a_toa_vs_tsym, clk, rst_n, out_valid, out_time_on_air_us >= TOA_W'(out_symbol_time_us), "time on air shorter than one symbol")

endmodule
